FILE: rtl/core/rcbd_pkg.sv
// ----------------------------------------------------------------------------
// rcbd_pkg
// Shared types, register map and constants of the crop and ordered dither block.
// ----------------------------------------------------------------------------
package rcbd_pkg;

  localparam int unsigned COORD_W = 11;
  localparam int unsigned OFFS_W  = 6;
  localparam int unsigned PIXEL_W = 16;
  localparam int unsigned BYTE_W  = 14;
  localparam int unsigned BITP_W  = 3;

  // APB register map: register index sits at paddr[2].
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_CROP_X = 1'b0;
  localparam logic        REG_CROP_Y = 1'b1;

  localparam logic [COORD_W-1:0] CROP_X_RST = 11'd160;
  localparam logic [COORD_W-1:0] CROP_Y_RST = 11'd120;

  // BT.601 luma weights, scaled by 256.
  localparam logic [7:0] LUMA_WR = 8'd77;
  localparam logic [7:0] LUMA_WG = 8'd150;
  localparam logic [7:0] LUMA_WB = 8'd29;

  // 8x8 Bayer matrix, row-major.
  localparam logic [5:0] BAYER [64] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

  function automatic logic [5:0] bayer_entry(input logic [2:0] row, input logic [2:0] col);
    return BAYER[{row, col}];
  endfunction

  typedef struct packed {
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    logic [OFFS_W-1:0]  col_in_tile;
    logic [OFFS_W-1:0]  row_in_tile;
    logic [PIXEL_W-1:0] pixel;
    logic               last_of_tile;
    logic               target_buffer;
  } pix_t;

  typedef struct packed {
    logic              in_window;
    logic [BYTE_W-1:0] byte_index;
    logic [BITP_W-1:0] bit_position;
    logic              black;
    logic              tile_done;
    logic              buffer_out;
  } res_t;

  // Per-stage load strobes from the pipeline control.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pipe_ctrl_t;

endpackage

FILE: rtl/core/rcbd_pix_if.sv
// ----------------------------------------------------------------------------
// rcbd_pix_if
// Valid/ready stream carrying one RGB565 pixel with its tile position.
// ----------------------------------------------------------------------------
interface rcbd_pix_if;
  logic                         valid;
  logic                         ready;
  logic [rcbd_pkg::COORD_W-1:0] tile_x;
  logic [rcbd_pkg::COORD_W-1:0] tile_y;
  logic [rcbd_pkg::OFFS_W-1:0]  col_in_tile;
  logic [rcbd_pkg::OFFS_W-1:0]  row_in_tile;
  logic [rcbd_pkg::PIXEL_W-1:0] pixel;
  logic                         last_of_tile;
  logic                         target_buffer;

  modport source (
    output valid, tile_x, tile_y, col_in_tile, row_in_tile, pixel, last_of_tile,
           target_buffer,
    input  ready
  );
  modport sink (
    input  valid, tile_x, tile_y, col_in_tile, row_in_tile, pixel, last_of_tile,
           target_buffer,
    output ready
  );
endinterface

FILE: rtl/core/rcbd_res_if.sv
// ----------------------------------------------------------------------------
// rcbd_res_if
// Valid/ready stream carrying one bitmap write result.
// ----------------------------------------------------------------------------
interface rcbd_res_if;
  logic                        valid;
  logic                        ready;
  logic                        in_window;
  logic [rcbd_pkg::BYTE_W-1:0] byte_index;
  logic [rcbd_pkg::BITP_W-1:0] bit_position;
  logic                        black;
  logic                        tile_done;
  logic                        buffer_out;

  modport source (
    output valid, in_window, byte_index, bit_position, black, tile_done, buffer_out,
    input  ready
  );
  modport sink (
    input  valid, in_window, byte_index, bit_position, black, tile_done, buffer_out,
    output ready
  );
endinterface

FILE: rtl/core/rcbd_cfg.sv
// ----------------------------------------------------------------------------
// rcbd_cfg
// APB register file holding the crop window origin.
// ----------------------------------------------------------------------------
module rcbd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rcbd_pkg::PADDR_W-1:0]  paddr,
  input  logic [rcbd_pkg::PDATA_W-1:0]  pwdata,
  output logic                          pready,
  output logic [rcbd_pkg::PDATA_W-1:0]  prdata,
  output logic [rcbd_pkg::COORD_W-1:0]  crop_x_o,
  output logic [rcbd_pkg::COORD_W-1:0]  crop_y_o
);
  import rcbd_pkg::*;

  logic [COORD_W-1:0] crop_x_q, crop_x_d;
  logic [COORD_W-1:0] crop_y_q, crop_y_d;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    crop_x_d = crop_x_q;
    crop_y_d = crop_y_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_CROP_X: crop_x_d = pwdata[COORD_W-1:0];
        REG_CROP_Y: crop_y_d = pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crop_x_q <= CROP_X_RST;
      crop_y_q <= CROP_Y_RST;
    end else begin
      crop_x_q <= crop_x_d;
      crop_y_q <= crop_y_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CROP_X: prdata = PDATA_W'(crop_x_q);
      REG_CROP_Y: prdata = PDATA_W'(crop_y_q);
      default:    prdata = '0;
    endcase
  end

  assign crop_x_o = crop_x_q;
  assign crop_y_o = crop_y_q;

endmodule

FILE: rtl/core/rcbd_datapath.sv
// ----------------------------------------------------------------------------
// rcbd_datapath
// Three register stages: position and channel products, window test with
// luma and row base, then bitmap address and dither decision.
// ----------------------------------------------------------------------------
module rcbd_datapath #(
  parameter int unsigned WIN_WIDTH  = 320,
  parameter int unsigned WIN_HEIGHT = 240
) (
  input  logic                          clk_i,
  input  rcbd_pkg::pipe_ctrl_t          ctrl_i,
  input  rcbd_pkg::pix_t                pix_i,
  input  logic [rcbd_pkg::COORD_W-1:0]  crop_x_i,
  input  logic [rcbd_pkg::COORD_W-1:0]  crop_y_i,
  output rcbd_pkg::res_t                res_o
);
  import rcbd_pkg::*;

  localparam int unsigned LX_W   = $clog2(WIN_WIDTH);
  localparam int unsigned LY_W   = $clog2(WIN_HEIGHT);
  localparam int unsigned AREA_W = $clog2(WIN_WIDTH * WIN_HEIGHT);
  localparam int unsigned IDX_W  = (AREA_W > BYTE_W + BITP_W) ? AREA_W : BYTE_W + BITP_W;
  localparam int unsigned POS_W  = COORD_W + 1;
  localparam int unsigned DIFF_W = COORD_W + 2;

  // Stage 1
  logic [DIFF_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [15:0]       pr_q, pr_d, pg_q, pg_d, pb_q, pb_d;
  logic              done1_q, buf1_q;

  // Stage 2
  logic              inside_q, inside_d;
  logic [LX_W-1:0]   lx_q;
  logic [IDX_W-1:0]  row_q, row_d;
  logic [7:0]        luma_q, luma_d;
  logic [5:0]        entry_q, entry_d;
  logic              done2_q, buf2_q;
  logic [16:0]       luma_sum;

  // Stage 3
  res_t              res_q, res_d;
  logic [IDX_W-1:0]  idx;
  logic [7:0]        contrast;
  logic signed [9:0] thr;

  // Stage 1: source position relative to the window origin, channel products.
  always_comb begin
    logic [POS_W-1:0] gx;
    logic [POS_W-1:0] gy;
    logic [7:0]       r8;
    logic [7:0]       g8;
    logic [7:0]       b8;
    gx   = POS_W'(pix_i.tile_x) + POS_W'(pix_i.col_in_tile);
    gy   = POS_W'(pix_i.tile_y) + POS_W'(pix_i.row_in_tile);
    dx_d = DIFF_W'(gx) - DIFF_W'(crop_x_i);
    dy_d = DIFF_W'(gy) - DIFF_W'(crop_y_i);
    r8   = {pix_i.pixel[15:11], 3'b000};
    g8   = {pix_i.pixel[10:5], 2'b00};
    b8   = {pix_i.pixel[4:0], 3'b000};
    pr_d = 16'(r8) * 16'(LUMA_WR);
    pg_d = 16'(g8) * 16'(LUMA_WG);
    pb_d = 16'(b8) * 16'(LUMA_WB);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      pr_q    <= pr_d;
      pg_q    <= pg_d;
      pb_q    <= pb_d;
      done1_q <= pix_i.last_of_tile;
      buf1_q  <= pix_i.target_buffer;
    end
  end

  // Stage 2: window test, luma, row base of the bitmap address, Bayer entry.
  // A negative difference has its top bit set, which also fails the upper bound.
  always_comb begin
    inside_d = (dx_q < DIFF_W'(WIN_WIDTH)) && (dy_q < DIFF_W'(WIN_HEIGHT));
    luma_sum = 17'(pr_q) + 17'(pg_q) + 17'(pb_q);
    luma_d   = luma_sum[15:8];
    row_d    = IDX_W'(IDX_W'(dy_q[LY_W-1:0]) * IDX_W'(WIN_WIDTH));
    entry_d  = bayer_entry(dy_q[2:0], dx_q[2:0]);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld2) begin
      inside_q <= inside_d;
      lx_q     <= dx_q[LX_W-1:0];
      row_q    <= row_d;
      luma_q   <= luma_d;
      entry_q  <= entry_d;
      done2_q  <= done1_q;
      buf2_q   <= buf1_q;
    end
  end

  // Stage 3: doubled contrast clamped to 0..255 against entry*4 - 128.
  always_comb begin
    idx = row_q + IDX_W'(lx_q);
    if (luma_q < 8'd64) begin
      contrast = 8'd0;
    end else if (luma_q >= 8'd192) begin
      contrast = 8'd255;
    end else begin
      contrast = 8'((luma_q - 8'd64) << 1);
    end
    thr = $signed({2'b00, entry_q, 2'b00}) - 10'sd128;

    res_d              = '0;
    res_d.tile_done    = done2_q;
    res_d.buffer_out   = buf2_q;
    if (inside_q) begin
      res_d.in_window    = 1'b1;
      res_d.byte_index   = idx[BITP_W +: BYTE_W];
      res_d.bit_position = ~idx[BITP_W-1:0];
      res_d.black        = $signed({2'b00, contrast}) < thr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld3) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: rtl/core/rgb565_crop_bayer_dither.sv
// ----------------------------------------------------------------------------
// rgb565_crop_bayer_dither
// Crops a tiled RGB565 pixel stream to a window and produces 1-bit ordered
// dither writes for a packed bitmap of that window.
// ----------------------------------------------------------------------------
// Path: each input transfer is registered through stage 1, stage 2 and stage 3 before its result is valid.
// Throughput: one pixel per cycle; the three pipeline stages each carry a
// valid bit and a stalled output holds while empty stages still fill.
// Reset: pipeline valid bits clear and the crop origin returns to (160, 120).
module rgb565_crop_bayer_dither #(
  parameter int unsigned WIN_WIDTH  = 320,
  parameter int unsigned WIN_HEIGHT = 240
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rcbd_pix_if.sink                      pix_i,
  rcbd_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rcbd_pkg::PADDR_W-1:0]  paddr,
  input  logic [rcbd_pkg::PDATA_W-1:0]  pwdata,
  output logic                          pready,
  output logic [rcbd_pkg::PDATA_W-1:0]  prdata
);
  import rcbd_pkg::*;

  logic [COORD_W-1:0] crop_x;
  logic [COORD_W-1:0] crop_y;
  pipe_ctrl_t         ctrl;
  pix_t               pix;
  res_t               res;
  logic               v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic               rdy1, rdy2, rdy3;

  rcbd_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .prdata   (prdata),
    .crop_x_o (crop_x),
    .crop_y_o (crop_y)
  );

  // A stage takes new data when it is empty or its contents move on.
  assign rdy3 = !v3_q || res_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign ctrl.ld1 = pix_i.valid && rdy1;
  assign ctrl.ld2 = v1_q && rdy2;
  assign ctrl.ld3 = v2_q && rdy3;

  assign v1_d = rdy1 ? pix_i.valid : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign pix_i.ready = rdy1;

  assign pix.tile_x        = pix_i.tile_x;
  assign pix.tile_y        = pix_i.tile_y;
  assign pix.col_in_tile   = pix_i.col_in_tile;
  assign pix.row_in_tile   = pix_i.row_in_tile;
  assign pix.pixel         = pix_i.pixel;
  assign pix.last_of_tile  = pix_i.last_of_tile;
  assign pix.target_buffer = pix_i.target_buffer;

  rcbd_datapath #(
    .WIN_WIDTH  (WIN_WIDTH),
    .WIN_HEIGHT (WIN_HEIGHT)
  ) u_datapath (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .pix_i    (pix),
    .crop_x_i (crop_x),
    .crop_y_i (crop_y),
    .res_o    (res)
  );

  assign res_o.valid        = v3_q;
  assign res_o.in_window    = res.in_window;
  assign res_o.byte_index   = res.byte_index;
  assign res_o.bit_position = res.bit_position;
  assign res_o.black        = res.black;
  assign res_o.tile_done    = res.tile_done;
  assign res_o.buffer_out   = res.buffer_out;

endmodule
